[design/apt_pkg.sv]
package apt_pkg;

  // Default widths of the coordinates and of the rotation coefficients.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF  = 16;

  // Width of the action selector carried on tuser.
  localparam int ACTION_WIDTH = 2;

  // Number of vector components.
  localparam int NUM_AXES = 3;

  // Actions applied to one input vector.
  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_FWD_POS = 2'd0,
    ACT_FWD_ORI = 2'd1,
    ACT_INV_POS = 2'd2,
    ACT_INV_ORI = 2'd3
  } action_t;

  // Configuration register indexes.
  localparam int REG_INDEX_WIDTH = 3;

  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_ROT_ROW0 = 3'd0,
    REG_ROT_ROW1 = 3'd1,
    REG_ROT_ROW2 = 3'd2,
    REG_TRANS_X  = 3'd3,
    REG_TRANS_Y  = 3'd4,
    REG_TRANS_Z  = 3'd5
  } reg_index_t;

endpackage

[design/affine_point_transform_core.sv]
// Applies a configured rigid transform to a stream of 3D vectors: forward
// position gives R*p+t, forward orientation R*p, inverse position R^T*(p-t)
// and inverse orientation R^T*p. R is a 3x3 matrix of signed coefficients
// with COEF_WIDTH-2 fraction bits; t and the coordinates are signed
// COORD_WIDTH-bit values in the same units. Each component is rounded half
// up and saturated, and the overflow flag on m_tuser marks any saturation.
// The block takes one vector per clock cycle unless the output stalls. Its
// four register stages are operand select, nine parallel multipliers,
// adder tree, and round and saturate. A stall on the output holds every
// occupied stage in place, while empty stages behind it keep filling. The
// user must write the matrix and translation over the APB port only while
// no vector is in flight; the block itself does not enforce this.
module affine_point_transform_core #(
  parameter int COORD_WIDTH = apt_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = apt_pkg::COEF_WIDTH_DEF,
  localparam int RowWidth   = 3 * COEF_WIDTH,
  localparam int DataWidth  = ((RowWidth > 32) || (COORD_WIDTH > 32))
                              ? ((RowWidth > 64) ? 128 : 64) : 32,
  localparam int AddrLsb    = (DataWidth > 32) ? 3 : 2,
  localparam int AddrWidth  = AddrLsb + apt_pkg::REG_INDEX_WIDTH,
  localparam int TdataWidth = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [AddrWidth-1:0]               paddr,
  input  logic [DataWidth-1:0]               pwdata,
  output logic [DataWidth-1:0]               prdata,
  output logic                               pready,
  // Input vectors.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [TdataWidth-1:0]              s_tdata,  // in_x, in_y, in_z
  input  logic [apt_pkg::ACTION_WIDTH-1:0]   s_tuser,  // action
  // Transformed vectors.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [TdataWidth-1:0]              m_tdata,  // out_x, out_y, out_z
  output logic                               m_tuser   // overflow
);

  import apt_pkg::*;

  localparam int Frac      = COEF_WIDTH - 2;
  localparam int VecWidth  = COORD_WIDTH + 1;
  localparam int ProdWidth = VecWidth + COEF_WIDTH;
  localparam int AccWidth  = COORD_WIDTH + COEF_WIDTH + 3;
  localparam int ShWidth   = AccWidth - Frac;
  localparam int PadWidth  = TdataWidth - 3 * COORD_WIDTH;

  localparam logic signed [AccWidth-1:0] Half = AccWidth'(1) <<< (Frac - 1);
  localparam logic [COORD_WIDTH-1:0] MaxVal = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MinVal = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Configuration registers.
  logic [RowWidth-1:0]    rot_row [NUM_AXES];
  logic [COORD_WIDTH-1:0] trans   [NUM_AXES];

  logic             cfg_write;
  reg_index_t       cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_index = reg_index_t'(paddr[AddrWidth-1:AddrLsb]);

  // Register writes; reset loads the identity transform.
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0] <= RowWidth'(1) << Frac;
      rot_row[1] <= RowWidth'(1) << (Frac + COEF_WIDTH);
      rot_row[2] <= RowWidth'(1) << (Frac + 2 * COEF_WIDTH);
      trans[0]   <= '0;
      trans[1]   <= '0;
      trans[2]   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROT_ROW0: rot_row[0] <= pwdata[RowWidth-1:0];
        REG_ROT_ROW1: rot_row[1] <= pwdata[RowWidth-1:0];
        REG_ROT_ROW2: rot_row[2] <= pwdata[RowWidth-1:0];
        REG_TRANS_X:  trans[0]   <= pwdata[COORD_WIDTH-1:0];
        REG_TRANS_Y:  trans[1]   <= pwdata[COORD_WIDTH-1:0];
        REG_TRANS_Z:  trans[2]   <= pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (cfg_index)
      REG_ROT_ROW0: prdata = DataWidth'(rot_row[0]);
      REG_ROT_ROW1: prdata = DataWidth'(rot_row[1]);
      REG_ROT_ROW2: prdata = DataWidth'(rot_row[2]);
      REG_TRANS_X:  prdata = DataWidth'(trans[0]);
      REG_TRANS_Y:  prdata = DataWidth'(trans[1]);
      REG_TRANS_Z:  prdata = DataWidth'(trans[2]);
      default:      prdata = '0;
    endcase
  end

  // Stage enables: a stage loads when it is empty or its contents move on.
  logic s1_valid, s2_valid, s3_valid;
  logic en1, en2, en3, en4;

  assign en4      = ~m_tvalid | m_tready;
  assign en3      = ~s3_valid | en4;
  assign en2      = ~s2_valid | en3;
  assign en1      = ~s1_valid | en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) s1_valid <= s_tvalid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
      if (en4) m_tvalid <= s3_valid;
    end
  end

  // Stage 1: decode the action, form p or p-t, pick R or its transpose.
  action_t act;
  logic    inverse, translate;
  logic signed [VecWidth-1:0]    vec_next  [NUM_AXES];
  logic signed [COEF_WIDTH-1:0]  coef_next [NUM_AXES][NUM_AXES];
  logic signed [COORD_WIDTH-1:0] tadd_next [NUM_AXES];

  assign act       = action_t'(s_tuser);
  assign inverse   = (act == ACT_INV_POS) || (act == ACT_INV_ORI);
  assign translate = (act == ACT_FWD_POS) || (act == ACT_INV_POS);

  always_comb begin
    for (int j = 0; j < NUM_AXES; j++) begin
      vec_next[j] = VecWidth'($signed(s_tdata[j*COORD_WIDTH +: COORD_WIDTH]));
      if (inverse && translate) begin
        vec_next[j] = vec_next[j] - VecWidth'($signed(trans[j]));
      end
      tadd_next[j] = (!inverse && translate) ? $signed(trans[j]) : '0;
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        coef_next[i][j] = inverse ? $signed(rot_row[j][i*COEF_WIDTH +: COEF_WIDTH])
                                  : $signed(rot_row[i][j*COEF_WIDTH +: COEF_WIDTH]);
      end
    end
  end

  logic signed [VecWidth-1:0]    s1_vec  [NUM_AXES];
  logic signed [COEF_WIDTH-1:0]  s1_coef [NUM_AXES][NUM_AXES];
  logic signed [COORD_WIDTH-1:0] s1_tadd [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_vec  <= vec_next;
      s1_coef <= coef_next;
      s1_tadd <= tadd_next;
    end
  end

  // Stage 2: nine products in parallel.
  logic signed [ProdWidth-1:0]   prod_next [NUM_AXES][NUM_AXES];
  logic signed [ProdWidth-1:0]   s2_prod   [NUM_AXES][NUM_AXES];
  logic signed [COORD_WIDTH-1:0] s2_tadd   [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        prod_next[i][j] = ProdWidth'(s1_vec[j]) * ProdWidth'(s1_coef[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_prod <= prod_next;
      s2_tadd <= s1_tadd;
    end
  end

  // Stage 3: sum the row with the scaled translation and the rounding half.
  logic signed [AccWidth-1:0] acc_next [NUM_AXES];
  logic signed [AccWidth-1:0] s3_acc   [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      acc_next[i] = AccWidth'(s2_prod[i][0]) + AccWidth'(s2_prod[i][1])
                  + AccWidth'(s2_prod[i][2])
                  + (AccWidth'(s2_tadd[i]) <<< Frac) + Half;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_acc <= acc_next;
    end
  end

  // Stage 4: drop the fraction bits and saturate each component.
  logic [ShWidth-1:0]     shifted  [NUM_AXES];
  logic [COORD_WIDTH-1:0] sat_next [NUM_AXES];
  logic [NUM_AXES-1:0]    ovf_axis;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      shifted[i]  = s3_acc[i][AccWidth-1:Frac];
      ovf_axis[i] = ~((&shifted[i][ShWidth-1:COORD_WIDTH-1]) |
                      (~|shifted[i][ShWidth-1:COORD_WIDTH-1]));
      if (!ovf_axis[i]) begin
        sat_next[i] = shifted[i][COORD_WIDTH-1:0];
      end else if (shifted[i][ShWidth-1]) begin
        sat_next[i] = MinVal;
      end else begin
        sat_next[i] = MaxVal;
      end
    end
  end

  logic [COORD_WIDTH-1:0] out_comp [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en4) begin
      out_comp <= sat_next;
      m_tuser  <= |ovf_axis;
    end
  end

  generate
    if (PadWidth > 0) begin : g_pad
      assign m_tdata = {{PadWidth{1'b0}}, out_comp[2], out_comp[1], out_comp[0]};
    end else begin : g_nopad
      assign m_tdata = {out_comp[2], out_comp[1], out_comp[0]};
    end
  endgenerate

endmodule

[tb/affine_point_transform_core_test.sv]
`timescale 1ns / 100ps

module affine_point_transform_core_test;
  import apt_pkg::*;

  localparam int FRAC = COEF_WIDTH_DEF - 2;
  localparam longint CoordMax = (longint'(1) <<< 31) - 1;
  localparam longint CoordMin = -(longint'(1) <<< 31);
  localparam int PhaseItems = 250;
  localparam int NumPhases = 7;

  // One transformed vector as it leaves the block.
  typedef struct {
    logic [95:0] vec;
    logic        ovf;
  } xform_result_t;

  // Keeps a copy of the matrix and translation, predicts each transformed
  // vector and checks the output beats against the predictions in order.
  class xform_scoreboard;
    logic [47:0]        rot_rows [3];
    logic signed [31:0] trans [3];
    xform_result_t      pending [$];
    int                 errors;

    function new();
      rot_rows[0] = 48'h0000_0000_4000;
      rot_rows[1] = 48'h0000_4000_0000;
      rot_rows[2] = 48'h4000_0000_0000;
      foreach (trans[i]) trans[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [63:0] value);
      case (idx)
        REG_ROT_ROW0: rot_rows[0] = value[47:0];
        REG_ROT_ROW1: rot_rows[1] = value[47:0];
        REG_ROT_ROW2: rot_rows[2] = value[47:0];
        REG_TRANS_X:  trans[0] = value[31:0];
        REG_TRANS_Y:  trans[1] = value[31:0];
        REG_TRANS_Z:  trans[2] = value[31:0];
        default: ;
      endcase
    endfunction

    // Signed coefficient of row r, column c.
    function longint coef(int r, int c);
      logic [47:0] row;
      row = rot_rows[r];
      return longint'($signed(row[16*c +: 16]));
    endfunction

    // Exact sums of products, then round half up and saturate each axis.
    function xform_result_t transform(action_t act, logic [95:0] vec);
      xform_result_t res;
      longint p [3];
      longint acc;
      bit inverse;
      bit translate;
      inverse = (act == ACT_INV_POS) || (act == ACT_INV_ORI);
      translate = (act == ACT_FWD_POS) || (act == ACT_INV_POS);
      res.ovf = 1'b0;
      for (int j = 0; j < 3; j++) begin
        p[j] = longint'($signed(vec[32*j +: 32]));
        if (inverse && translate) p[j] = p[j] - longint'(trans[j]);
      end
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          acc = acc + p[j] * (inverse ? coef(j, i) : coef(i, j));
        end
        if (!inverse && translate) acc = acc + (longint'(trans[i]) <<< FRAC);
        acc = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        if (acc > CoordMax) begin
          res.vec[32*i +: 32] = 32'h7FFF_FFFF;
          res.ovf = 1'b1;
        end else if (acc < CoordMin) begin
          res.vec[32*i +: 32] = 32'h8000_0000;
          res.ovf = 1'b1;
        end else begin
          res.vec[32*i +: 32] = acc[31:0];
        end
      end
      return res;
    endfunction

    function void note_input(action_t act, logic [95:0] vec);
      pending.push_back(transform(act, vec));
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [95:0] vec, logic ovf);
      xform_result_t want;
      string axis [3];
      axis = '{"x", "y", "z"};
      if (pending.size() == 0) begin
        report($sformatf("output beat %h/%b with no vector pending", vec, ovf));
      end else begin
        want = pending.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (vec[32*i +: 32] !== want.vec[32*i +: 32])
            report($sformatf("out_%s got %h, predicted %h", axis[i],
                             vec[32*i +: 32], want.vec[32*i +: 32]));
        end
        if (ovf !== want.ovf)
          report($sformatf("overflow got %b, predicted %b", ovf, want.ovf));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;   // in_x, in_y, in_z
  logic [1:0]  s_tuser = '0;   // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;        // out_x, out_y, out_z
  logic        m_tuser;        // overflow
  bit          quiet = 1'b0;

  xform_scoreboard sb;

  affine_point_transform_core u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // The output side stalls about 12 beats in a hundred, except when quiet.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(0, 99) >= 12);
    end
  end

  // Note accepted input beats and check accepted output beats.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_input(action_t'(s_tuser), s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // APB write: setup phase, then access phase, then back to idle.
  task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic write_config(input logic [47:0] rows [3], input logic [31:0] tr [3]);
    write_reg(REG_ROT_ROW0, {16'h0, rows[0]});
    write_reg(REG_ROT_ROW1, {16'h0, rows[1]});
    write_reg(REG_ROT_ROW2, {16'h0, rows[2]});
    write_reg(REG_TRANS_X, {32'h0, tr[0]});
    write_reg(REG_TRANS_Y, {32'h0, tr[1]});
    write_reg(REG_TRANS_Z, {32'h0, tr[2]});
  endtask

  // Send one vector beat, with random idle cycles ahead of it.
  task automatic send_vec(input action_t act, input logic [95:0] vec);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= vec;
    s_tuser <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted vector has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6: return $urandom_range(0, 1 << 21) - (1 << 20);
      7: return $urandom_range(0, 255) - 128;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    logic [15:0] picks [5];
    picks = '{16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h0000};
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom_range(0, 65535));
      3, 4, 5: return 16'($urandom_range(0, 32768) - 16384);
      default: return picks[$urandom_range(0, 4)];
    endcase
  endfunction

  initial begin : main
    action_t     all_acts [4];
    logic [47:0] rows [3];
    logic [31:0] tr [3];
    logic [95:0] vecs [3];
    sb = new();
    all_acts = '{ACT_FWD_POS, ACT_FWD_ORI, ACT_INV_POS, ACT_INV_ORI};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Identity matrix straight out of reset.
    send_vec(ACT_FWD_POS, {32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF});
    send_vec(ACT_INV_ORI, {32'h0000_0001, 32'h0, 32'h8000_0000});
    drain();

    // Identity with extreme translation: forward sums and the wide inverse
    // difference both overflow the coordinate range.
    rows = '{48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000};
    tr = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
    write_config(rows, tr);
    foreach (all_acts[a]) begin
      send_vec(all_acts[a], {32'h0, 32'h8000_0000, 32'h7FFF_FFFF});
      send_vec(all_acts[a], {32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
    end
    drain();

    // Extreme and half-valued coefficients: rounding of exact halves in
    // both signs, and a matrix that is far from orthogonal.
    rows = '{{16'h2000, 16'h7FFF, 16'h8000}, {16'h8000, 16'h0001, 16'hE000},
             {16'h7FFF, 16'h7FFF, 16'h7FFF}};
    tr = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    write_config(rows, tr);
    vecs = '{{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
             {32'h0000_0003, 32'hFFFF_FFFF, 32'h0000_0001},
             {32'h0000_0001, 32'hFFFF_FFFD, 32'h0000_0003}};
    foreach (all_acts[a]) begin
      foreach (vecs[v]) send_vec(all_acts[a], vecs[v]);
    end
    drain();

    // Random phases, each under its own matrix and translation.
    for (int ph = 0; ph < NumPhases; ph++) begin
      for (int r = 0; r < 3; r++) begin
        case (ph)
          0: begin
            rows[r] = {3{16'h7FFF}};
            tr[r] = 32'h7FFF_FFFF;
          end
          1: begin
            rows[r] = {3{16'h8000}};
            tr[r] = 32'h8000_0000;
          end
          default: begin
            rows[r] = {rand_coef(), rand_coef(), rand_coef()};
            tr[r] = rand_coord();
          end
        endcase
      end
      write_config(rows, tr);
      quiet = (ph == 3);
      repeat (PhaseItems) begin
        send_vec(action_t'($urandom_range(0, 3)),
                 {rand_coord(), rand_coord(), rand_coord()});
      end
      drain();
      quiet = 1'b0;
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("affine_point_transform_core_test: PASS");
    end else begin
      $display("affine_point_transform_core_test: FAIL");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("affine_point_transform_core_test: FAIL");
    $finish;
  end

endmodule

[files.f]
design/apt_pkg.sv
design/affine_point_transform_core.sv
tb/affine_point_transform_core_test.sv
